@@ rtl/jrs_pkg.sv @@
// ----------------------------------------------------------------------------
// jrs_pkg: shared types and constants of the json record splitter
// character codes, field widths, register map and scanner phase encoding
// ----------------------------------------------------------------------------
`default_nettype none

package jrs_pkg;

   // field widths
   localparam int BYTE_W  = 8;
   localparam int COUNT_W = 24;
   localparam int DEPTH_W = 16;

   // configuration port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_ADDR_W-3:0] REG_BATCH_LEN = 1'b0;

   localparam logic [COUNT_W-1:0] BATCH_LEN_RESET = COUNT_W'(500000);

   // characters that steer the scanner
   localparam logic [BYTE_W-1:0] CH_OPEN   = 8'h7B;
   localparam logic [BYTE_W-1:0] CH_CLOSE  = 8'h7D;
   localparam logic [BYTE_W-1:0] CH_QUOTE  = 8'h22;
   localparam logic [BYTE_W-1:0] CH_BSLASH = 8'h5C;

   // scanner phase: waiting for the outer brace, inside the object, done
   typedef enum logic [2:0] {
      PH_WAIT = 3'b001,
      PH_SCAN = 3'b010,
      PH_DONE = 3'b100
   } phase_type;

endpackage

`default_nettype wire

@@ rtl/jrs_if.sv @@
// ----------------------------------------------------------------------------
// jrs_if: stream channels of the json record splitter
// valid/ready channels for raw text bytes and for tagged output bytes
// ----------------------------------------------------------------------------
`default_nettype none

interface jrs_req_if;
   logic                        valid;
   logic                        ready;
   logic [jrs_pkg::BYTE_W-1:0]  in_byte;

   modport source (output valid, output in_byte, input ready);
   modport sink   (input valid, input in_byte, output ready);
endinterface

interface jrs_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [jrs_pkg::BYTE_W-1:0]  out_byte;
   logic                        byte_valid;
   logic                        entry_end;
   logic                        batch_end;
   logic                        object_end;
   logic                        depth_overflow;

   modport source (output valid, output out_byte, output byte_valid, output entry_end,
                   output batch_end, output object_end, output depth_overflow,
                   input ready);
   modport sink   (input valid, input out_byte, input byte_valid, input entry_end,
                   input batch_end, input object_end, input depth_overflow,
                   output ready);
endinterface

`default_nettype wire

@@ rtl/json_record_splitter.sv @@
// ----------------------------------------------------------------------------
// json_record_splitter: brace-depth record splitter for a json byte stream
// tags each byte of the outer object with entry, batch and object boundaries
// ----------------------------------------------------------------------------
// One byte is taken per clock while rsp_ch does not stall, and each byte inside
// the outer object yields one tagged transfer on rsp_ch from the output register;
// bytes before the first opening brace, that brace itself, and everything after
// the closing outer brace give no transfer. The scanner state (phase, string and
// escape flags, 16-bit depth counter, 24-bit entry count) updates in the same
// cycle the byte is taken, and a single output register holds the result, so a
// new byte is taken whenever that register is empty or is being drained.
// Sustained rate: one byte per cycle while rsp_ch does not stall. The batch
// length register (byte address 0, reset 500000, 0 acts as 1) sets how many
// entry ends make a batch end; write it only while the stream is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module json_record_splitter (
   input  wire logic                              clock,
   input  wire logic                              reset,
   jrs_req_if.sink                                req_ch,
   jrs_rsp_if.source                              rsp_ch,
   input  wire logic                              csr_psel,
   input  wire logic                              csr_penable,
   input  wire logic                              csr_pwrite,
   input  wire logic [jrs_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  wire logic [jrs_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic      [jrs_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                                   csr_pready
);

   localparam logic [jrs_pkg::DEPTH_W-1:0] DEPTH_ONE  = jrs_pkg::DEPTH_W'(1);
   localparam logic [jrs_pkg::DEPTH_W-1:0] DEPTH_ZERO = '0;
   localparam logic [jrs_pkg::DEPTH_W-1:0] DEPTH_MAX  = '1;

   // configuration
   logic [jrs_pkg::COUNT_W-1:0]   batch_len_ff;
   logic [jrs_pkg::COUNT_W-1:0]   batch_len_in;
   logic                          csr_write;
   logic                          csr_hit;

   // scanner state
   jrs_pkg::phase_type            phase_ff;
   jrs_pkg::phase_type            phase_in;
   logic                          in_str_ff;
   logic                          in_str_in;
   logic                          esc_ff;
   logic                          esc_in;
   logic [jrs_pkg::DEPTH_W-1:0]   depth_ff;
   logic [jrs_pkg::DEPTH_W-1:0]   depth_in;
   logic [jrs_pkg::COUNT_W-1:0]   count_ff;
   logic [jrs_pkg::COUNT_W-1:0]   count_in;

   // per-byte decode
   logic                          req_take;
   logic [jrs_pkg::BYTE_W-1:0]    cur_byte;
   logic                          is_open;
   logic                          is_close;
   logic                          is_quote;
   logic                          is_bslash;
   logic [jrs_pkg::DEPTH_W-1:0]   depth_dec;
   logic [jrs_pkg::COUNT_W-1:0]   count_inc;
   logic [jrs_pkg::COUNT_W-1:0]   batch_lim;

   // result of the byte being taken
   logic                          res_load;
   logic                          res_byte_valid;
   logic                          res_entry_end;
   logic                          res_batch_end;
   logic                          res_object_end;
   logic                          res_overflow;

   // output register
   logic                          rsp_valid_ff;
   logic                          rsp_valid_in;
   logic [jrs_pkg::BYTE_W-1:0]    rsp_byte_ff;
   logic                          rsp_byte_valid_ff;
   logic                          rsp_entry_end_ff;
   logic                          rsp_batch_end_ff;
   logic                          rsp_object_end_ff;
   logic                          rsp_overflow_ff;

   // ---------------------------------------------------------------------------
   // configuration port: zero-wait writes, register 0 holds the batch length
   // ---------------------------------------------------------------------------
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_hit    = (csr_paddr[jrs_pkg::CSR_ADDR_W-1:2] == jrs_pkg::REG_BATCH_LEN);

   always_comb begin
      batch_len_in = batch_len_ff;
      if (csr_write && csr_hit) begin
         batch_len_in = csr_pwdata[jrs_pkg::COUNT_W-1:0];
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_hit) begin
         csr_prdata = jrs_pkg::CSR_DATA_W'(batch_len_ff);
      end
   end

   // ---------------------------------------------------------------------------
   // input side: take a byte whenever the output register can be refilled
   // ---------------------------------------------------------------------------
   assign req_ch.ready = ~rsp_valid_ff | rsp_ch.ready;
   assign req_take     = req_ch.valid & req_ch.ready;
   assign cur_byte     = req_ch.in_byte;

   assign is_open   = (cur_byte == jrs_pkg::CH_OPEN);
   assign is_close  = (cur_byte == jrs_pkg::CH_CLOSE);
   assign is_quote  = (cur_byte == jrs_pkg::CH_QUOTE);
   assign is_bslash = (cur_byte == jrs_pkg::CH_BSLASH);

   // closing brace never drives the depth below zero
   assign depth_dec = (depth_ff != DEPTH_ZERO) ? depth_ff - DEPTH_ONE : DEPTH_ZERO;
   assign count_inc = count_ff + jrs_pkg::COUNT_W'(1);
   // a zero batch length behaves as one
   assign batch_lim = (batch_len_ff != '0) ? batch_len_ff : jrs_pkg::COUNT_W'(1);

   // ---------------------------------------------------------------------------
   // scanner: escape beats quote, quote beats braces, braces only outside strings
   // ---------------------------------------------------------------------------
   always_comb begin
      phase_in       = phase_ff;
      in_str_in      = in_str_ff;
      esc_in         = esc_ff;
      depth_in       = depth_ff;
      count_in       = count_ff;
      res_load       = 1'b0;
      res_byte_valid = 1'b1;
      res_entry_end  = 1'b0;
      res_batch_end  = 1'b0;
      res_object_end = 1'b0;
      res_overflow   = 1'b0;
      if (req_take) begin
         case (phase_ff)
            jrs_pkg::PH_WAIT: begin
               // leading bytes and the outer brace give no transfer
               if (is_open) begin
                  phase_in = jrs_pkg::PH_SCAN;
                  depth_in = DEPTH_ONE;
               end
            end
            jrs_pkg::PH_SCAN: begin
               res_load = 1'b1;
               if (esc_ff) begin
                  esc_in = 1'b0;
               end else if (is_bslash && in_str_ff) begin
                  esc_in = 1'b1;
               end else if (is_quote) begin
                  in_str_in = ~in_str_ff;
               end else if (in_str_ff) begin
                  // plain string content
                  esc_in = 1'b0;
               end else if (is_open) begin
                  // saturate at the top and flag this byte only
                  if (depth_ff == DEPTH_MAX) begin
                     res_overflow = 1'b1;
                  end else begin
                     depth_in = depth_ff + DEPTH_ONE;
                  end
               end else if (is_close) begin
                  depth_in = depth_dec;
                  if (depth_dec == DEPTH_ONE) begin
                     // entry closed: count it against the batch
                     res_entry_end = 1'b1;
                     if (count_inc >= batch_lim) begin
                        res_batch_end = 1'b1;
                        count_in      = '0;
                     end else begin
                        count_in = count_inc;
                     end
                  end else if (depth_dec == DEPTH_ZERO) begin
                     // outer object closed: last transfer of the stream
                     phase_in       = jrs_pkg::PH_DONE;
                     res_object_end = 1'b1;
                     res_byte_valid = 1'b0;
                  end
               end
            end
            jrs_pkg::PH_DONE: begin
               // everything past the outer brace is swallowed
               phase_in = jrs_pkg::PH_DONE;
            end
            default: begin
               phase_in = jrs_pkg::PH_WAIT;
            end
         endcase
      end
   end

   // ---------------------------------------------------------------------------
   // output register: loaded on a producing byte, emptied by a transfer
   // ---------------------------------------------------------------------------
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (res_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         batch_len_ff  <= jrs_pkg::BATCH_LEN_RESET;
         phase_ff      <= jrs_pkg::PH_WAIT;
         in_str_ff     <= 1'b0;
         esc_ff        <= 1'b0;
         depth_ff      <= DEPTH_ZERO;
         count_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         batch_len_ff  <= batch_len_in;
         phase_ff      <= phase_in;
         in_str_ff     <= in_str_in;
         esc_ff        <= esc_in;
         depth_ff      <= depth_in;
         count_ff      <= count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload needs no reset
   always_ff @(posedge clock) begin
      if (res_load) begin
         rsp_byte_ff       <= cur_byte;
         rsp_byte_valid_ff <= res_byte_valid;
         rsp_entry_end_ff  <= res_entry_end;
         rsp_batch_end_ff  <= res_batch_end;
         rsp_object_end_ff <= res_object_end;
         rsp_overflow_ff   <= res_overflow;
      end
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.out_byte       = rsp_byte_ff;
   assign rsp_ch.byte_valid     = rsp_byte_valid_ff;
   assign rsp_ch.entry_end      = rsp_entry_end_ff;
   assign rsp_ch.batch_end      = rsp_batch_end_ff;
   assign rsp_ch.object_end     = rsp_object_end_ff;
   assign rsp_ch.depth_overflow = rsp_overflow_ff;

`ifndef NO_ASSERTIONS
   // nothing is produced once the outer object has closed
   a_done_silent: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == jrs_pkg::PH_DONE) |-> !res_load)
      else $error("result produced after the outer object closed");

   // a batch end always rides on an entry end
   a_batch_on_entry: assert property (@(posedge clock) disable iff (reset)
      (res_load && res_batch_end) |-> res_entry_end)
      else $error("batch end without entry end");

   // the entry count restarts after a batch end
   a_count_restart: assert property (@(posedge clock) disable iff (reset)
      (res_load && res_batch_end) |=> (count_ff == '0))
      else $error("entry count not cleared after batch end");

   // overflow only when the depth counter is pinned at its maximum
   a_overflow_sat: assert property (@(posedge clock) disable iff (reset)
      (res_load && res_overflow) |=> (depth_ff == DEPTH_MAX))
      else $error("depth overflow without saturated counter");

   // the object end closes the stream with a non-content brace
   a_object_end: assert property (@(posedge clock) disable iff (reset)
      (res_load && res_object_end) |=> (phase_ff == jrs_pkg::PH_DONE) && !rsp_byte_valid_ff)
      else $error("object end did not close the stream");
`endif

endmodule

`default_nettype wire
